### rtl/boundary_fd_first_derivative_macros.svh
// ----------------------------------------------------------------------------
// boundary_fd_first_derivative assertion macros
// Shared concurrent assertion forms for the boundary derivative block.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_FD_FIRST_DERIVATIVE_MACROS_SVH
`define BOUNDARY_FD_FIRST_DERIVATIVE_MACROS_SVH

// same-cycle implication, reset masks the check
`define BFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfd assertion failed");

// next-cycle implication, reset masks the check
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfd assertion failed");

`endif

### rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Widths, stencil codes, weight table and pipeline control types.
// ----------------------------------------------------------------------------
package bfd_pkg;

    // sample format
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_BITS  = 32;
    localparam int DIST_BITS   = 10;

    // stencil geometry
    localparam int N_TAPS      = 9;
    localparam int GROUP_SIZE  = 3;
    localparam int GROUPS      = N_TAPS / GROUP_SIZE;
    localparam int WEIGHT_BITS = 7;

    // weighted sum bound is 128 * 2^(SAMPLE_BITS-1)
    localparam int SUM_BITS    = SAMPLE_BITS + 8;
    localparam int MAG_BITS    = SUM_BITS - 1;
    localparam int LO_BITS     = (MAG_BITS + 1) / 2;
    localparam int HI_BITS     = MAG_BITS - LO_BITS;
    localparam int PROD_BITS   = MAG_BITS + SCALE_BITS;
    localparam int RND_BITS    = PROD_BITS - FRAC_BITS;

    // pipeline depth from accept to result register
    localparam int STAGES      = 7;

    // tap positions
    localparam int TAP_M4 = 0;
    localparam int TAP_M3 = 1;
    localparam int TAP_M2 = 2;
    localparam int TAP_M1 = 3;
    localparam int TAP_C  = 4;
    localparam int TAP_P1 = 5;
    localparam int TAP_P2 = 6;
    localparam int TAP_P3 = 7;
    localparam int TAP_P4 = 8;

    // saturation limits
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CENTERED   = 3'd0,
        ST_FORWARD    = 3'd1,
        ST_BACKWARD   = 3'd2,
        ST_FWD_BIASED = 3'd3,
        ST_BWD_BIASED = 3'd4,
        ST_FALLBACK   = 3'd5
    } stencil_t;

    typedef logic signed [WEIGHT_BITS-1:0] weight_row_t [N_TAPS];
    typedef logic signed [SUM_BITS-1:0]    term_array_t [N_TAPS];

    typedef struct packed {
        logic en_s2;
        logic en_s3;
    } merge_ctl_t;

    typedef struct packed {
        logic en_s4;
        logic en_s5;
        logic en_s6;
        logic en_s7;
    } scale_ctl_t;

    // stencil choice, first match wins
    function automatic stencil_t pick_stencil(logic [DIST_BITS-1:0] lo,
                                              logic [DIST_BITS-1:0] hi);
        stencil_t sel;
        if (lo >= DIST_BITS'(2) && hi >= DIST_BITS'(2)) begin
            sel = ST_CENTERED;
        end else if (lo < DIST_BITS'(1) && hi >= DIST_BITS'(4)) begin
            sel = ST_FORWARD;
        end else if (hi < DIST_BITS'(1) && lo >= DIST_BITS'(4)) begin
            sel = ST_BACKWARD;
        end else if (lo >= DIST_BITS'(1) && hi >= DIST_BITS'(3)) begin
            sel = ST_FWD_BIASED;
        end else if (hi >= DIST_BITS'(1) && lo >= DIST_BITS'(3)) begin
            sel = ST_BWD_BIASED;
        end else begin
            sel = ST_FALLBACK;
        end
        return sel;
    endfunction

    // integer weights over 12 for each stencil
    function automatic weight_row_t stencil_row(stencil_t sel);
        weight_row_t row;
        for (int i = 0; i < N_TAPS; i++) begin
            row[i] = '0;
        end
        unique case (sel)
            ST_CENTERED: begin
                row[TAP_M2] = WEIGHT_BITS'(1);
                row[TAP_M1] = WEIGHT_BITS'(-8);
                row[TAP_P1] = WEIGHT_BITS'(8);
                row[TAP_P2] = WEIGHT_BITS'(-1);
            end
            ST_FORWARD: begin
                row[TAP_C]  = WEIGHT_BITS'(-25);
                row[TAP_P1] = WEIGHT_BITS'(48);
                row[TAP_P2] = WEIGHT_BITS'(-36);
                row[TAP_P3] = WEIGHT_BITS'(16);
                row[TAP_P4] = WEIGHT_BITS'(-3);
            end
            ST_BACKWARD: begin
                row[TAP_M4] = WEIGHT_BITS'(3);
                row[TAP_M3] = WEIGHT_BITS'(-16);
                row[TAP_M2] = WEIGHT_BITS'(36);
                row[TAP_M1] = WEIGHT_BITS'(-48);
                row[TAP_C]  = WEIGHT_BITS'(25);
            end
            ST_FWD_BIASED: begin
                row[TAP_M1] = WEIGHT_BITS'(-3);
                row[TAP_C]  = WEIGHT_BITS'(-10);
                row[TAP_P1] = WEIGHT_BITS'(18);
                row[TAP_P2] = WEIGHT_BITS'(-6);
                row[TAP_P3] = WEIGHT_BITS'(1);
            end
            ST_BWD_BIASED: begin
                row[TAP_M3] = WEIGHT_BITS'(-1);
                row[TAP_M2] = WEIGHT_BITS'(6);
                row[TAP_M1] = WEIGHT_BITS'(-18);
                row[TAP_C]  = WEIGHT_BITS'(10);
                row[TAP_P1] = WEIGHT_BITS'(3);
            end
            default: begin
                row[TAP_M1] = WEIGHT_BITS'(-6);
                row[TAP_P1] = WEIGHT_BITS'(6);
            end
        endcase
        return row;
    endfunction

endpackage

### rtl/bfd_lane.sv
// ----------------------------------------------------------------------------
// bfd_lane
// One tap lane: sample times stencil weight, registered at full sum width.
// ----------------------------------------------------------------------------
module bfd_lane (
    input  logic                                      aclk,
    input  logic                                      en,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic signed [bfd_pkg::WEIGHT_BITS-1:0]    weight,
    output logic signed [bfd_pkg::SUM_BITS-1:0]       term_reg
);

    logic signed [bfd_pkg::SAMPLE_BITS+bfd_pkg::WEIGHT_BITS-1:0] prod;
    logic signed [bfd_pkg::SUM_BITS-1:0]                         term_next;

    // small signed product, sign-extended to the sum width
    always_comb begin
        prod      = sample * weight;
        term_next = bfd_pkg::SUM_BITS'(prod);
    end

    // lane register
    always_ff @(posedge aclk) begin
        if (en) begin
            term_reg <= term_next;
        end
    end

endmodule

### rtl/bfd_merge.sv
// ----------------------------------------------------------------------------
// bfd_merge
// Two-level registered adder tree that merges the lane products.
// ----------------------------------------------------------------------------
module bfd_merge (
    input  logic                                  aclk,
    input  bfd_pkg::merge_ctl_t                   ctl,
    input  bfd_pkg::term_array_t                  terms,
    output logic signed [bfd_pkg::SUM_BITS-1:0]   sum_reg
);

    logic signed [bfd_pkg::SUM_BITS-1:0] group_reg  [bfd_pkg::GROUPS];
    logic signed [bfd_pkg::SUM_BITS-1:0] group_next [bfd_pkg::GROUPS];
    logic signed [bfd_pkg::SUM_BITS-1:0] sum_next;

    // first level: partial sums over groups of lanes
    always_comb begin
        for (int g = 0; g < bfd_pkg::GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < bfd_pkg::GROUP_SIZE; j++) begin
                group_next[g] = group_next[g] + terms[g*bfd_pkg::GROUP_SIZE + j];
            end
        end
    end

    // second level: total
    always_comb begin
        sum_next = '0;
        for (int g = 0; g < bfd_pkg::GROUPS; g++) begin
            sum_next = sum_next + group_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_s2) begin
            group_reg <= group_next;
        end
        if (ctl.en_s3) begin
            sum_reg <= sum_next;
        end
    end

endmodule

### rtl/bfd_scale.sv
// ----------------------------------------------------------------------------
// bfd_scale
// Sign split, split scale multiply, rounding and saturation of the sum.
// ----------------------------------------------------------------------------
module bfd_scale (
    input  logic                                  aclk,
    input  bfd_pkg::scale_ctl_t                   ctl,
    input  logic signed [bfd_pkg::SUM_BITS-1:0]   sum_in,
    input  logic [bfd_pkg::SCALE_BITS-1:0]        scale_in,
    output logic [bfd_pkg::SAMPLE_BITS-1:0]       derivative_reg,
    output logic                                  saturated_reg
);

    localparam int SB = bfd_pkg::SAMPLE_BITS;

    logic                                               neg_s4_reg;
    logic [bfd_pkg::MAG_BITS-1:0]                       mag_reg;
    logic [bfd_pkg::MAG_BITS-1:0]                       mag_next;
    logic                                               neg_s5_reg;
    logic [bfd_pkg::LO_BITS+bfd_pkg::SCALE_BITS-1:0]    pp_lo_reg;
    logic [bfd_pkg::HI_BITS+bfd_pkg::SCALE_BITS-1:0]    pp_hi_reg;
    logic                                               neg_s6_reg;
    logic [bfd_pkg::RND_BITS-1:0]                       rnd_reg;
    logic [bfd_pkg::PROD_BITS-1:0]                      prod;
    logic [bfd_pkg::PROD_BITS-1:0]                      half;
    logic                                               sat_next;
    logic [SB-1:0]                                      res_next;
    logic [SB-1:0]                                      neg_val;

    // magnitude of the weighted sum
    always_comb begin
        if (sum_in[bfd_pkg::SUM_BITS-1]) begin
            mag_next = bfd_pkg::MAG_BITS'(-sum_in);
        end else begin
            mag_next = bfd_pkg::MAG_BITS'(sum_in);
        end
    end

    // recombine partial products, add half an lsb, drop fraction bits
    always_comb begin
        half = bfd_pkg::PROD_BITS'(1) << (bfd_pkg::FRAC_BITS - 1);
        prod = bfd_pkg::PROD_BITS'(pp_lo_reg)
             + (bfd_pkg::PROD_BITS'(pp_hi_reg) << bfd_pkg::LO_BITS)
             + half;
    end

    // clip to the signed sample range
    always_comb begin
        neg_val = -rnd_reg[SB-1:0];
        if (neg_s6_reg) begin
            sat_next = (|rnd_reg[bfd_pkg::RND_BITS-1:SB])
                    || (rnd_reg[SB-1] && (|rnd_reg[SB-2:0]));
            res_next = sat_next ? bfd_pkg::SAT_MIN : neg_val;
        end else begin
            sat_next = |rnd_reg[bfd_pkg::RND_BITS-1:SB-1];
            res_next = sat_next ? bfd_pkg::SAT_MAX : rnd_reg[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_s4) begin
            neg_s4_reg <= sum_in[bfd_pkg::SUM_BITS-1];
            mag_reg    <= mag_next;
        end
        if (ctl.en_s5) begin
            neg_s5_reg <= neg_s4_reg;
            pp_lo_reg  <= mag_reg[bfd_pkg::LO_BITS-1:0] * scale_in;
            pp_hi_reg  <= mag_reg[bfd_pkg::MAG_BITS-1:bfd_pkg::LO_BITS] * scale_in;
        end
        if (ctl.en_s6) begin
            neg_s6_reg <= neg_s5_reg;
            rnd_reg    <= prod[bfd_pkg::PROD_BITS-1:bfd_pkg::FRAC_BITS];
        end
        if (ctl.en_s7) begin
            derivative_reg <= res_next;
            saturated_reg  <= sat_next;
        end
    end

endmodule

### rtl/boundary_fd_first_derivative.sv
// Throughput: one word per cycle unless a held output word (m_ready low)
// backs up a full pipeline; nine lane multipliers, a two-level adder tree
// and a two-part scale multiplier are all pipelined. Any empty stage takes
// a new word even while the output word is held.
// Reset (aresetn low, synchronous) empties the pipeline and sets the
// scale register to 1.0 (65536).
// ----------------------------------------------------------------------------
// boundary_fd_first_derivative
// Boundary-aware fourth-order first derivative: stencil select, lanes,
// merge tree and scaling with rounding and saturation.
// ----------------------------------------------------------------------------
`include "boundary_fd_first_derivative_macros.svh"

module boundary_fd_first_derivative (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [bfd_pkg::SCALE_BITS-1:0]         cfg_wr_data,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_m4,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_m3,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_m2,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_m1,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_c,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_p1,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_p2,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_p3,
    input  logic signed [bfd_pkg::SAMPLE_BITS-1:0] s_sample_p4,
    input  logic [bfd_pkg::DIST_BITS-1:0]          s_dist_low,
    input  logic [bfd_pkg::DIST_BITS-1:0]          s_dist_high,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bfd_pkg::SAMPLE_BITS-1:0] m_derivative,
    output logic [2:0]                             m_stencil_used,
    output logic                                   m_saturated
);

    localparam int NS = bfd_pkg::STAGES;

    logic [bfd_pkg::SCALE_BITS-1:0]        scale_reg;
    logic [NS:1]                           v_reg;
    logic [NS:1]                           v_next;
    logic [NS:1]                           en;
    bfd_pkg::stencil_t                     sel_reg [1:NS];
    bfd_pkg::stencil_t                     sel_in;
    bfd_pkg::weight_row_t                  w_row;
    logic signed [bfd_pkg::SAMPLE_BITS-1:0] samples [bfd_pkg::N_TAPS];
    bfd_pkg::term_array_t                  terms;
    logic signed [bfd_pkg::SUM_BITS-1:0]   sum;
    bfd_pkg::merge_ctl_t                   merge_ctl;
    bfd_pkg::scale_ctl_t                   scale_ctl;
    logic [bfd_pkg::SAMPLE_BITS-1:0]       deriv;
    logic                                  sat;

    // scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= bfd_pkg::SCALE_BITS'(65536);
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    // stage enables: a stage loads when empty or when its word moves on
    always_comb begin
        en[NS] = !v_reg[NS] || m_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[1]) begin
            v_next[1] = s_valid;
        end
        for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // stencil code travels alongside the data
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sel_reg[1] <= sel_in;
        end
        for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
                sel_reg[k] <= sel_reg[k-1];
            end
        end
    end

    // stencil pick and weight row for the incoming word
    always_comb begin
        sel_in = bfd_pkg::pick_stencil(s_dist_low, s_dist_high);
        w_row  = bfd_pkg::stencil_row(sel_in);
    end

    assign samples[bfd_pkg::TAP_M4] = s_sample_m4;
    assign samples[bfd_pkg::TAP_M3] = s_sample_m3;
    assign samples[bfd_pkg::TAP_M2] = s_sample_m2;
    assign samples[bfd_pkg::TAP_M1] = s_sample_m1;
    assign samples[bfd_pkg::TAP_C]  = s_sample_c;
    assign samples[bfd_pkg::TAP_P1] = s_sample_p1;
    assign samples[bfd_pkg::TAP_P2] = s_sample_p2;
    assign samples[bfd_pkg::TAP_P3] = s_sample_p3;
    assign samples[bfd_pkg::TAP_P4] = s_sample_p4;

    // one lane per tap
    for (genvar i = 0; i < bfd_pkg::N_TAPS; i++) begin : g_lane
        bfd_lane u_lane (
            .aclk     (aclk),
            .en       (en[1]),
            .sample   (samples[i]),
            .weight   (w_row[i]),
            .term_reg (terms[i])
        );
    end

    // merge tree
    always_comb begin
        merge_ctl.en_s2 = en[2];
        merge_ctl.en_s3 = en[3];
    end

    bfd_merge u_merge (
        .aclk    (aclk),
        .ctl     (merge_ctl),
        .terms   (terms),
        .sum_reg (sum)
    );

    // scaling, rounding and clipping
    always_comb begin
        scale_ctl.en_s4 = en[4];
        scale_ctl.en_s5 = en[5];
        scale_ctl.en_s6 = en[6];
        scale_ctl.en_s7 = en[7];
    end

    bfd_scale u_scale (
        .aclk           (aclk),
        .ctl            (scale_ctl),
        .sum_in         (sum),
        .scale_in       (scale_reg),
        .derivative_reg (deriv),
        .saturated_reg  (sat)
    );

    // ports
    assign s_ready        = en[1];
    assign m_valid        = v_reg[NS];
    assign m_derivative   = deriv;
    assign m_saturated    = sat;
    assign m_stencil_used = sel_reg[NS];

    // checks
    `BFD_ASSERT_NOW(a_sat_at_limit, aclk, aresetn, m_valid && m_saturated, m_derivative == bfd_pkg::SAT_MAX || m_derivative == bfd_pkg::SAT_MIN)
    `BFD_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready && (&v_reg))
    `BFD_ASSERT_NEXT(a_accept_loads_s1, aclk, aresetn, s_valid && s_ready, v_reg[1])

endmodule
